// File: rtl/crc_checked_frame_extractor_macros.svh
// assertion macros for the crc checked frame extractor
// used by the top level only, no other dependencies
`ifndef CRC_CHECKED_FRAME_EXTRACTOR_MACROS_SVH
`define CRC_CHECKED_FRAME_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define CCFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CCFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ccfe_pkg.sv
// package for the crc checked frame extractor: constants, state type, crc steps
// no dependencies
package ccfe_pkg;

   localparam int BUFFER_DEPTH_DEF = 512;
   localparam int MAX_RESULTS      = 57;
   localparam int MIN_FRAME        = 9;
   localparam int HDR_LAST         = 6;

   localparam logic [7:0]  SOF_BYTE   = 8'hA5;
   localparam logic [7:0]  CRC8_INIT  = 8'hFF;
   localparam logic [7:0]  CRC8_POLY  = 8'h8C;
   localparam logic [15:0] CRC16_INIT = 16'hFFFF;
   localparam logic [15:0] CRC16_POLY = 16'h8408;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_TICK   = 1'b1;
   localparam logic RES_PACKET  = 1'b0;
   localparam logic RES_ALIVE   = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
      logic [7:0] r;
      r = c ^ d;
      for (int b = 0; b < 8; b++) begin
         r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

// File: rtl/crc_checked_frame_extractor.sv
// crc checked frame extractor: burst buffer memory and frame scan sequencer
// depends on ccfe_pkg and crc_checked_frame_extractor_macros.svh
//
//   channel  ports                 direction  carries
//   req      req_valid/req_stall   in         received byte or alive tick
//   rsp      rsp_valid/rsp_stall   out        packet found or alive report
//
// a byte or tick transaction is taken while idle, once the output
// register is free. after the last byte the scan walks the buffer
// through a one-port memory, reading the header of each candidate
// position and then the rest of its frame, one byte read per cycle.
// reset clears all control state; buffer contents need no clearing.
// rsp_stall holds the output register, holds off req and pauses the scan while a found packet waits to move out.
`include "crc_checked_frame_extractor_macros.svh"

module crc_checked_frame_extractor
   import ccfe_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_burst_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_command_id,
   output logic [15:0] rsp_payload_length,
   output logic [7:0]  rsp_sequence_number,
   output logic [8:0]  rsp_start_offset,
   output logic        rsp_link_alive,
   output logic        rsp_run_last
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int NW = $clog2(MAX_RESULTS + 1);

   // burst buffer memory
   logic [7:0] buf_mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   // control state
   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [15:0]     pkt_cnt_ff, pkt_cnt_in;
   logic [15:0]     last_tick_ff, last_tick_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic [NW-1:0]   hits_ff, hits_in;
   logic [16:0]     issue_ff, issue_in;
   logic [16:0]     stop_ff, stop_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [16:0]     rd_idx_ff;

   // frame capture
   logic [7:0]  crc8_ff, crc8_in;
   logic [15:0] crc16_ff, crc16_in;
   logic        sof_ok_ff, sof_ok_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [7:0]  got_lo_ff, got_lo_in;

   // pending packet, held until we know whether another follows
   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_cmd_ff, pend_dlen_ff;
   logic [7:0]  pend_seq_ff;
   logic [8:0]  pend_off_ff;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_alive_ff, out_last_ff;
   logic [15:0] out_cmd_ff, out_dlen_ff;
   logic [7:0]  out_seq_ff;
   logic [8:0]  out_off_ff;
   logic        out_load_pend, out_load_tick, out_load_last;

   logic        out_free;
   logic        req_take;
   logic        issue;
   logic [AW-1:0] rd_addr;
   logic [17:0] addr_sum;
   logic [16:0] whole;
   logic [17:0] frame_end;
   logic        fits;
   logic        more;
   logic [CW-1:0] pos_step, pos_skip;
   logic        alive_now;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   // read address for the byte in flight
   assign addr_sum  = 18'(pos_ff) + 18'(issue_ff);
   assign rd_addr   = addr_sum[AW-1:0];
   assign issue     = (state_ff == ST_RUN) && (issue_ff < stop_ff);

   // frame geometry
   assign whole     = 17'(dlen_ff) + 17'(MIN_FRAME);
   assign frame_end = 18'(pos_ff) + 18'(whole);
   assign fits      = frame_end <= 18'(count_ff);
   assign more      = (18'(pos_ff) + 18'(MIN_FRAME) <= 18'(count_ff)) &&
                      (hits_ff < NW'(MAX_RESULTS));
   assign pos_step  = pos_ff + CW'(1);
   assign pos_skip  = frame_end[CW-1:0];
   assign alive_now = pkt_cnt_ff != last_tick_ff;

   // memory: write on byte transactions, registered read during scan
   always_ff @(posedge clock) begin
      if (req_take && (req_type == KIND_BYTE) && (count_ff < CW'(BUFFER_DEPTH))) begin
         buf_mem[count_ff[AW-1:0]] <= req_rx_byte;
      end
      if (issue) begin
         rd_data_ff <= buf_mem[rd_addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pkt_cnt_in    = pkt_cnt_ff;
      last_tick_in  = last_tick_ff;
      pos_in        = pos_ff;
      hits_in       = hits_ff;
      issue_in      = issue_ff;
      stop_in       = stop_ff;
      rd_valid_in   = issue;
      crc8_in       = crc8_ff;
      crc16_in      = crc16_ff;
      sof_ok_in     = sof_ok_ff;
      hdr_ok_in     = hdr_ok_ff;
      dlen_in       = dlen_ff;
      seq_in        = seq_ff;
      cmd_in        = cmd_ff;
      got_lo_in     = got_lo_ff;
      pend_valid_in = pend_valid_ff;
      out_load_pend = 1'b0;
      out_load_tick = 1'b0;
      out_load_last = 1'b0;

      if (issue) begin
         issue_in = issue_ff + 17'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_type == KIND_TICK) begin
                  out_load_tick = 1'b1;
                  last_tick_in  = pkt_cnt_ff;
               end else begin
                  if (count_ff < CW'(BUFFER_DEPTH)) begin
                     count_in = count_ff + CW'(1);
                  end
                  if (req_burst_last) begin
                     pos_in   = '0;
                     hits_in  = '0;
                     state_in = ST_START;
                  end
               end
            end
         end
         ST_START: begin
            // set up a candidate at pos_ff, or end the scan
            issue_in    = '0;
            stop_in     = 17'(HDR_LAST + 1);
            rd_valid_in = 1'b0;
            crc8_in     = CRC8_INIT;
            crc16_in    = CRC16_INIT;
            hdr_ok_in   = 1'b0;
            state_in    = more ? ST_RUN : ST_FLUSH;
         end
         ST_RUN: begin
            if (rd_valid_ff) begin
               if (rd_idx_ff < 17'd4) begin
                  crc8_in = crc8_byte(crc8_ff, rd_data_ff);
               end
               if ((rd_idx_ff <= 17'(HDR_LAST)) || (rd_idx_ff + 17'd2 < whole)) begin
                  crc16_in = crc16_byte(crc16_ff, rd_data_ff);
               end
               case (rd_idx_ff)
                  17'd0: sof_ok_in = rd_data_ff == SOF_BYTE;
                  17'd1: dlen_in = {dlen_ff[15:8], rd_data_ff};
                  17'd2: dlen_in = {rd_data_ff, dlen_ff[7:0]};
                  17'd3: seq_in = rd_data_ff;
                  17'd4: hdr_ok_in = sof_ok_ff && (crc8_ff == rd_data_ff);
                  17'd5: cmd_in = {cmd_ff[15:8], rd_data_ff};
                  17'd6: begin
                     cmd_in = {rd_data_ff, cmd_ff[7:0]};
                     if (hdr_ok_ff && fits) begin
                        stop_in = whole;
                     end else begin
                        pos_in   = pos_step;
                        state_in = ST_START;
                     end
                  end
                  default: begin
                     if (rd_idx_ff + 17'd2 == whole) begin
                        got_lo_in = rd_data_ff;
                     end
                     if (rd_idx_ff + 17'd1 == whole) begin
                        if (crc16_ff == {rd_data_ff, got_lo_ff}) begin
                           state_in = ST_EMIT;
                        end else begin
                           pos_in   = pos_step;
                           state_in = ST_START;
                        end
                     end
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // older pending packet moves out, this one becomes pending
            if (!pend_valid_ff || out_free) begin
               out_load_pend = pend_valid_ff;
               pend_valid_in = 1'b1;
               pos_in        = pos_skip;
               hits_in       = hits_ff + NW'(1);
               pkt_cnt_in    = pkt_cnt_ff + 16'd1;
               state_in      = ST_START;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               count_in = '0;
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load_pend = 1'b1;
               out_load_last = 1'b1;
               pend_valid_in = 1'b0;
               count_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load_pend || out_load_tick) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pkt_cnt_ff    <= '0;
         last_tick_ff  <= '0;
         pos_ff        <= '0;
         hits_ff       <= '0;
         issue_ff      <= '0;
         stop_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         hdr_ok_ff     <= 1'b0;
         sof_ok_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pkt_cnt_ff    <= pkt_cnt_in;
         last_tick_ff  <= last_tick_in;
         pos_ff        <= pos_in;
         hits_ff       <= hits_in;
         issue_ff      <= issue_in;
         stop_ff       <= stop_in;
         rd_valid_ff   <= rd_valid_in;
         hdr_ok_ff     <= hdr_ok_in;
         sof_ok_ff     <= sof_ok_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= issue_ff;
      crc8_ff   <= crc8_in;
      crc16_ff  <= crc16_in;
      dlen_ff   <= dlen_in;
      seq_ff    <= seq_in;
      cmd_ff    <= cmd_in;
      got_lo_ff <= got_lo_in;
      if ((state_ff == ST_EMIT) && (!pend_valid_ff || out_free)) begin
         pend_cmd_ff  <= cmd_ff;
         pend_dlen_ff <= dlen_ff;
         pend_seq_ff  <= seq_ff;
         pend_off_ff  <= 9'(pos_ff);
      end
      if (out_load_tick) begin
         out_kind_ff  <= RES_ALIVE;
         out_cmd_ff   <= '0;
         out_dlen_ff  <= '0;
         out_seq_ff   <= '0;
         out_off_ff   <= '0;
         out_alive_ff <= alive_now;
         out_last_ff  <= 1'b1;
      end else if (out_load_pend) begin
         out_kind_ff  <= RES_PACKET;
         out_cmd_ff   <= pend_cmd_ff;
         out_dlen_ff  <= pend_dlen_ff;
         out_seq_ff   <= pend_seq_ff;
         out_off_ff   <= pend_off_ff;
         out_alive_ff <= 1'b0;
         out_last_ff  <= out_load_last;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_kind     = out_kind_ff;
   assign rsp_command_id      = out_cmd_ff;
   assign rsp_payload_length  = out_dlen_ff;
   assign rsp_sequence_number = out_seq_ff;
   assign rsp_start_offset    = out_off_ff;
   assign rsp_link_alive      = out_alive_ff;
   assign rsp_run_last        = out_last_ff;

   // checks
   `CCFE_ASSERT_NOW(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff,
      "packet left pending after scan")
   `CCFE_ASSERT_NOW(a_rd_in_run, clock, reset, rd_valid_ff, state_ff == ST_RUN,
      "memory read outside scan")
   `CCFE_ASSERT_NOW(a_hits_max, clock, reset, 1'b1, hits_ff <= NW'(MAX_RESULTS),
      "result limit exceeded")
   `CCFE_ASSERT_NEXT(a_last_starts, clock, reset,
      req_take && (req_type == KIND_BYTE) && req_burst_last, state_ff == ST_START,
      "last byte did not start scan")

endmodule
